// ===== rtl/byte_level_token_text_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// byte level token text decoder assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef BYTE_LEVEL_TOKEN_TEXT_DECODER_DEFINES_SVH
`define BYTE_LEVEL_TOKEN_TEXT_DECODER_DEFINES_SVH

// same-cycle implication
`define BLTD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BLTD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bltd_pkg.sv =====
// ----------------------------------------------------------------------------
// bltd_pkg
// types and helper functions for the byte level token text decoder
// ----------------------------------------------------------------------------
`default_nettype none

package bltd_pkg;

  localparam logic [7:0] SPACE_B0   = 8'hE2;
  localparam logic [7:0] SPACE_B1   = 8'h96;
  localparam logic [7:0] SPACE_B2   = 8'h81;
  localparam logic [7:0] SPACE_CHAR = 8'h20;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // one decode step on the head of the buffer
  typedef struct packed {
    logic [7:0] data;
    logic [2:0] adv;
    logic [1:0] raw_rem;
  } chr_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] data;
  } map_t;

  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    begin
      if (b[7] == 1'b0) len = 3'd1;
      else if ((b & 8'hE0) == 8'hC0) len = 3'd2;
      else if ((b & 8'hF0) == 8'hE0) len = 3'd3;
      else if ((b & 8'hF8) == 8'hF0) len = 3'd4;
      else len = 3'd0;
      return len;
    end
  endfunction

  function automatic map_t table_byte(input logic [20:0] cp);
    map_t       m;
    logic [7:0] k;
    begin
      m = '0;
      k = cp[7:0];
      if ((cp >= 21'd33 && cp <= 21'd126) || (cp >= 21'd161 && cp <= 21'd172) ||
          (cp >= 21'd174 && cp <= 21'd255)) begin
        m.hit  = 1'b1;
        m.data = cp[7:0];
      end else if (cp >= 21'd256 && cp <= 21'd323) begin
        m.hit = 1'b1;
        if (k < 8'd33) m.data = k;
        else if (k < 8'd67) m.data = k + 8'd94;
        else m.data = 8'd173;
      end
      return m;
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bltd_char_unit.sv =====
// ----------------------------------------------------------------------------
// bltd_char_unit
// decodes the character at the head of the byte buffer into one output byte
// ----------------------------------------------------------------------------
`default_nettype none

module bltd_char_unit import bltd_pkg::*; (
  input  wire logic [31:0] buf_data,
  input  wire logic [2:0]  rem,
  output chr_t             chr
);

  logic [7:0]  b0, b1, b2, b3;
  logic [2:0]  len;
  logic [20:0] cp;
  map_t        m;

  assign b0  = buf_data[7:0];
  assign b1  = buf_data[15:8];
  assign b2  = buf_data[23:16];
  assign b3  = buf_data[31:24];
  assign len = lead_length(b0);

  always_comb begin
    case (len)
      3'd2:    cp = {10'd0, b0[4:0], b1[5:0]};
      3'd3:    cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
      3'd4:    cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
      default: cp = {13'd0, b0};
    endcase
  end

  assign m = table_byte(cp);

  always_comb begin
    chr = '0;
    if (rem >= 3'd3 && b0 == SPACE_B0 && b1 == SPACE_B1 && b2 == SPACE_B2) begin
      chr.data = SPACE_CHAR;
      chr.adv  = 3'd3;
    end else if (len == 3'd0 || len > rem) begin
      chr.data = b0;
      chr.adv  = 3'd1;
    end else if (m.hit) begin
      chr.data = m.data;
      chr.adv  = len;
    end else begin
      chr.data    = b0;
      chr.adv     = 3'd1;
      chr.raw_rem = 2'(len - 3'd1);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/byte_level_token_text_decoder.sv =====
// byte level token text decoder
//
// in channel: one stored text byte per transaction, in_last on the token's
// final byte. out channel: decoded bytes, out_last on the token's final one.
// lead and continuation bytes of an unfinished character are held and the
// transaction gives no output.
// when a character completes, a stray byte arrives or in_last is seen, the
// buffer (1 to 4 bytes) is handed to the sequencer, which walks it through
// the shared character unit and emits one output byte per cycle unless the
// receiver stalls. the accept starts the sequencer (ST_RUN), whose first step
// loads the output register. a transaction gives 0 to 4 output bytes;
// in_ready is low while the sequencer runs, so no byte is taken until it idles.
// the output register lets the next input be accepted while the last
// result still waits; a stalled receiver freezes the sequencer.
// reset (rst_n low, synchronous) clears the held character and the output.
// ----------------------------------------------------------------------------
// byte_level_token_text_decoder
// byte-level bpe token text to raw bytes decoder, iterative sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module byte_level_token_text_decoder import bltd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  in_t       in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  state_t      state_r, state_nxt;
  logic [31:0] buf_r, buf_nxt;
  logic [2:0]  rem_r, rem_nxt;
  logic [1:0]  raw_r, raw_nxt;
  logic        last_r, last_nxt;
  logic [1:0]  held_r, held_nxt;
  logic [2:0]  seq_r, seq_nxt;
  logic        ov_r, ov_nxt;
  out_t        od_r, od_nxt;

  chr_t        chr;
  logic        accept, run, emit_ok, emit;
  logic [2:0]  n_new, len_in, adv, rem_left;
  logic [7:0]  emit_byte;

  bltd_char_unit u_chr (
    .buf_data (buf_r),
    .rem      (rem_r),
    .chr      (chr)
  );

  assign accept   = in_valid && in_ready;
  assign n_new    = {1'b0, held_r} + 3'd1;
  assign len_in   = lead_length(in_data.in_byte);
  assign emit_ok  = !ov_r || out_ready;
  assign emit     = (state_r == ST_RUN) && emit_ok;
  assign rem_left = rem_r - adv;

  always_comb begin
    if (held_r == 2'd0) run = in_data.in_last || len_in <= 3'd1;
    else run = in_data.in_last || n_new >= seq_r || n_new >= 3'd4;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept && run) state_nxt = ST_RUN;
      ST_RUN:  if (emit && rem_left == 3'd0) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    buf_nxt   = buf_r;
    rem_nxt   = rem_r;
    raw_nxt   = raw_r;
    last_nxt  = last_r;
    held_nxt  = held_r;
    seq_nxt   = seq_r;
    ov_nxt    = ov_r && !out_ready;
    od_nxt    = od_r;
    adv       = 3'd1;
    emit_byte = buf_r[7:0];
    if (raw_r == 2'd0) begin
      adv       = chr.adv;
      emit_byte = chr.data;
    end
    if (accept) begin
      buf_nxt[{held_r, 3'b000} +: 8] = in_data.in_byte;
      if (run) begin
        rem_nxt  = n_new;
        raw_nxt  = 2'd0;
        last_nxt = in_data.in_last;
        held_nxt = 2'd0;
        seq_nxt  = 3'd0;
      end else begin
        held_nxt = 2'(n_new);
        if (held_r == 2'd0) seq_nxt = len_in;
      end
    end
    if (emit) begin
      buf_nxt         = buf_r >> {adv, 3'b000};
      rem_nxt         = rem_left;
      raw_nxt         = (raw_r != 2'd0) ? raw_r - 2'd1 : chr.raw_rem;
      ov_nxt          = 1'b1;
      od_nxt.out_byte = emit_byte;
      od_nxt.out_last = last_r && rem_left == 3'd0;
    end
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      held_r  <= '0;
      seq_r   <= '0;
      ov_r    <= 1'b0;
      rem_r   <= '0;
      raw_r   <= '0;
    end else begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
      seq_r   <= seq_nxt;
      ov_r    <= ov_nxt;
      rem_r   <= rem_nxt;
      raw_r   <= raw_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r  <= buf_nxt;
    last_r <= last_nxt;
    od_r   <= od_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/bltd_checker.sv =====
// ----------------------------------------------------------------------------
// bltd_checker
// port level checks for the byte level token text decoder
// ----------------------------------------------------------------------------
`default_nettype none

`include "byte_level_token_text_decoder_defines.svh"

module bltd_checker import bltd_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input in_t       in_data,
  input wire logic out_valid,
  input wire logic out_ready,
  input out_t      out_data
);

  // stalled output holds
  `BLTD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "output changed while stalled")

  // a token end always starts a decode run
  `BLTD_ASSERT_NEXT(a_last_busy, in_valid && in_ready && in_data.in_last, !in_ready, "ready after token end")

  // offered output transaction carries known bits
  `BLTD_ASSERT_NOW(a_out_known, out_valid, !$isunknown(out_data), "unknown output payload")

endmodule

bind byte_level_token_text_decoder bltd_checker u_bltd_checker (.*);

`default_nettype wire
